/* rtl/pcrc_pkg.sv */
package pcrc_pkg;

    localparam logic [15:0] SEED_RESET = 16'hB0CA;
    localparam logic [7:0]  PAD_BYTE   = 8'h00;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef logic [1:0] held_count_t;

    // byte-wise CRC-16 CCITT, xor-shift form
    function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]} ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

endpackage

/* rtl/pcrc_if.sv */
interface pcrc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pcrc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  packet_status;
    logic [15:0] computed_crc;

    modport source (output valid, output packet_status, output computed_crc, input ready);
    modport sink   (input valid, input packet_status, input computed_crc, output ready);
endinterface

interface pcrc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] crc_seed;

    modport source (output valid, output crc_seed, input ready);
    modport sink   (input valid, input crc_seed, output ready);
endinterface

/* rtl/packet_crc16_checker.sv */
// Packet CRC-16 checker.
// pkt: one packet byte per transfer, last_byte marks the final byte. The last
//   two bytes of a packet are the trailer (CRC low byte, then high byte).
// res: one transfer per packet, on its final byte: packet_status (match,
//   mismatch, or packet shorter than three bytes) and computed_crc (zero for a
//   short packet; includes a zero pad byte when the payload length is odd).
// cfg: write of crc_seed, always ready; used from the next packet start.
//   Write only while no packet is in flight.
// Throughput: one byte per cycle unless stalled (below). A byte is registered
//   on its transfer and processed when it leaves the input register; the
//   result register is loaded as the final byte is processed. The CRC path per
//   cycle is at most two byte-wise CRC steps in series and a 16-bit compare.
// Stall: while a result waits, non-final bytes still flow; a final byte waits
//   in the input register and pkt.ready drops only then.
// Reset: pipeline empties, no packet in progress, seed returns to 0xB0CA.
module packet_crc16_checker
    import pcrc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pcrc_in_if.sink      pkt,
    pcrc_out_if.source   res,
    pcrc_cfg_if.sink     cfg
);

    logic        in_valid_reg;
    logic [7:0]  in_data_reg;
    logic        in_last_reg;

    logic [15:0] seed_reg;
    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  older_reg, older_next;
    logic [7:0]  newer_reg, newer_next;
    held_count_t held_reg,  held_next;
    logic        odd_reg,   odd_next;

    logic        out_valid_reg;
    status_t     out_status_reg, out_status_next;
    logic [15:0] out_crc_reg,    out_crc_next;

    logic        advance;
    logic        take_in;
    logic [15:0] base_crc;
    logic        base_odd;
    logic [15:0] final_crc;

    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || res.ready);
    assign pkt.ready = !in_valid_reg || advance;
    assign take_in = pkt.valid && pkt.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        base_crc = (held_reg == 2'd0) ? seed_reg : crc_reg;
        base_odd = (held_reg == 2'd0) ? 1'b0 : odd_reg;
        if (held_reg == 2'd2)
        begin
            crc_next = crc_update(base_crc, older_reg);
            odd_next = !base_odd;
        end
        else
        begin
            crc_next = base_crc;
            odd_next = base_odd;
        end
        older_next = newer_reg;
        newer_next = in_data_reg;
        held_next  = (held_reg == 2'd2) ? 2'd2 : held_reg + 2'd1;

        final_crc = odd_next ? crc_update(crc_next, PAD_BYTE) : crc_next;
        if (held_reg != 2'd2)
        begin
            out_status_next = STATUS_SHORT;
            out_crc_next    = 16'h0000;
        end
        else
        begin
            out_crc_next = final_crc;
            if (final_crc[7:0] == newer_reg && final_crc[15:8] == in_data_reg)
                out_status_next = STATUS_MATCH;
            else
                out_status_next = STATUS_MISMATCH;
        end
        if (in_last_reg)
        begin
            held_next = 2'd0;
            odd_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= 2'd0;
            odd_reg       <= 1'b0;
            seed_reg      <= SEED_RESET;
        end
        else
        begin
            if (cfg.valid)
                seed_reg <= cfg.crc_seed;
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                held_reg <= held_next;
                odd_reg  <= odd_next;
            end
            if (advance && in_last_reg)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_data_reg <= pkt.data_byte;
            in_last_reg <= pkt.last_byte;
        end
        if (advance)
        begin
            crc_reg   <= crc_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
        if (advance && in_last_reg)
        begin
            out_status_reg <= out_status_next;
            out_crc_reg    <= out_crc_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.packet_status = out_status_reg;
    assign res.computed_crc  = out_crc_reg;

    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg != 2'd3)
        else $error("held count out of range");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_SHORT |-> out_crc_reg == 16'h0000)
        else $error("short packet with non-zero crc");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_last_reg |=> held_reg == 2'd0 && !odd_reg)
        else $error("packet state not cleared at end");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> in_last_reg && out_valid_reg && !res.ready)
        else $error("input stalled without a waiting result");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_last_reg))
        else $error("result without a final byte");

endmodule
